/* sv/u8u16_pkg.sv */
// Shared types, constants and byte-class helpers for the UTF-8 to UTF-16 decoder.
// No dependencies; imported by every module of the block.
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
    localparam logic [7:0]  ASCII_TOP  = 8'h80;
    localparam logic [7:0]  MASK_C0    = 8'hC0;
    localparam logic [7:0]  MASK_E0    = 8'hE0;
    localparam logic [7:0]  MASK_F0    = 8'hF0;
    localparam logic [7:0]  MASK_F8    = 8'hF8;
    localparam logic [7:0]  CODE_CONT  = 8'h80;
    localparam logic [7:0]  CODE_LEAD2 = 8'hC0;
    localparam logic [7:0]  CODE_LEAD3 = 8'hE0;
    localparam logic [7:0]  CODE_LEAD4 = 8'hF0;

    // held_count codes
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_LEAD = 2'd1;
    localparam logic [1:0] HELD_PAIR = 2'd2;

    // bytes dropped after a four-byte lead
    localparam logic [1:0] SKIP_LEN = 2'd3;

    localparam int QUEUE_DEPTH_DEF = 4;

    // One byte's worth of results: all units but the last are 0xFFFD.
    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] last_unit;
    } u8u16_group_t;

    typedef struct packed {
        logic        empty;
        logic        full;
    } u8u16_qstat_t;

    typedef struct packed {
        logic        emit;
        logic [15:0] unit;
        logic        hold;
        logic        skip;
    } u8u16_lead_t;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & MASK_C0) == CODE_CONT;
    endfunction

    function automatic logic is_lead2(input logic [7:0] b);
        return (b & MASK_E0) == CODE_LEAD2;
    endfunction

    function automatic logic is_lead3(input logic [7:0] b);
        return (b & MASK_F0) == CODE_LEAD3;
    endfunction

    function automatic logic is_lead4(input logic [7:0] b);
        return (b & MASK_F8) == CODE_LEAD4;
    endfunction

    // Examine a byte as the start of a new sequence.
    function automatic u8u16_lead_t take_lead(input logic [7:0] b, input logic eot);
        u8u16_lead_t r;
        r = '0;
        if (b < ASCII_TOP)
        begin
            r.emit = 1'b1;
            r.unit = {8'h00, b};
        end
        else if ((is_lead2(b) || is_lead3(b)) && !eot)
        begin
            r.hold = 1'b1;
        end
        else if (is_lead4(b))
        begin
            r.emit = 1'b1;
            r.unit = REPL_UNIT;
            r.skip = !eot;
        end
        else
        begin
            r.emit = 1'b1;
            r.unit = REPL_UNIT;
        end
        return r;
    endfunction

endpackage

/* sv/u8u16_front.sv */
// Front end: classifies each byte against the held sequence state, forms one result group.
// Depends on u8u16_pkg.
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  logic [7:0]   data_byte,
    input  logic         end_of_text,
    output logic         grp_valid,
    output u8u16_group_t grp
);

    logic [1:0] held_count_reg, held_count_next;
    logic [7:0] held_lead_reg, held_lead_next;
    logic [7:0] held_cont_reg, held_cont_next;
    logic [1:0] skip_left_reg, skip_left_next;
    u8u16_lead_t tl;

    always_comb
    begin
        tl = take_lead(data_byte, end_of_text);
        held_count_next = HELD_NONE;
        held_lead_next  = '0;
        held_cont_next  = '0;
        skip_left_next  = '0;
        grp.count       = 2'd0;
        grp.last_unit   = REPL_UNIT;

        if (skip_left_reg != 2'd0)
        begin
            skip_left_next = skip_left_reg - 2'd1;
        end
        else
        begin
            unique case (held_count_reg)
                HELD_LEAD:
                begin
                    if (is_cont(data_byte) && is_lead2(held_lead_reg))
                    begin
                        grp.count     = 2'd1;
                        grp.last_unit = {5'd0, held_lead_reg[4:0], data_byte[5:0]};
                    end
                    else if (is_cont(data_byte) && is_lead3(held_lead_reg) && !end_of_text)
                    begin
                        held_count_next = HELD_PAIR;
                        held_lead_next  = held_lead_reg;
                        held_cont_next  = data_byte;
                    end
                    else
                    begin
                        // failed lead, then re-examine the byte as a lead
                        grp.count     = 2'd1 + {1'b0, tl.emit};
                        grp.last_unit = tl.emit ? tl.unit : REPL_UNIT;
                        if (tl.hold)
                        begin
                            held_count_next = HELD_LEAD;
                            held_lead_next  = data_byte;
                        end
                        skip_left_next = tl.skip ? SKIP_LEN : 2'd0;
                    end
                end
                HELD_PAIR:
                begin
                    if (is_cont(data_byte))
                    begin
                        grp.count     = 2'd1;
                        grp.last_unit = {held_lead_reg[3:0], held_cont_reg[5:0],
                                         data_byte[5:0]};
                    end
                    else
                    begin
                        grp.count     = 2'd2 + {1'b0, tl.emit};
                        grp.last_unit = tl.emit ? tl.unit : REPL_UNIT;
                        if (tl.hold)
                        begin
                            held_count_next = HELD_LEAD;
                            held_lead_next  = data_byte;
                        end
                        skip_left_next = tl.skip ? SKIP_LEN : 2'd0;
                    end
                end
                default:
                begin
                    grp.count     = {1'b0, tl.emit};
                    grp.last_unit = tl.unit;
                    if (tl.hold)
                    begin
                        held_count_next = HELD_LEAD;
                        held_lead_next  = data_byte;
                    end
                    skip_left_next = tl.skip ? SKIP_LEN : 2'd0;
                end
            endcase
        end

        // end of text clears everything
        if (end_of_text)
        begin
            held_count_next = HELD_NONE;
            held_lead_next  = '0;
            held_cont_next  = '0;
            skip_left_next  = '0;
        end
        grp_valid = take && (grp.count != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= HELD_NONE;
            held_lead_reg  <= '0;
            held_cont_reg  <= '0;
            skip_left_reg  <= '0;
        end
        else if (take)
        begin
            held_count_reg <= held_count_next;
            held_lead_reg  <= held_lead_next;
            held_cont_reg  <= held_cont_next;
            skip_left_reg  <= skip_left_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("held_count out of range");

    a_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_left_reg != 2'd0) |-> (held_count_reg == HELD_NONE))
        else $error("skip while bytes held");
`endif

endmodule

/* sv/u8u16_queue.sv */
// Short FIFO of result groups between the front and back ends.
// Depends on u8u16_pkg.
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  u8u16_group_t wr_grp,
    input  logic         rd,
    output u8u16_group_t head,
    output u8u16_qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8u16_group_t entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign head       = entries[rd_ptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (rd && !wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            entries[wr_ptr_reg] <= wr_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |-> !stat.full)
        else $error("group queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> !stat.empty)
        else $error("group queue underflow");
`endif

endmodule

/* sv/u8u16_back.sv */
// Back end: expands queued groups into single code units behind an output register.
// Depends on u8u16_pkg.
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  u8u16_group_t head,
    input  u8u16_qstat_t qstat,
    output logic         q_rd,
    input  logic         pop,
    output logic         empty,
    output logic [15:0]  code_unit,
    output logic         run_last
);

    logic [1:0]  sent_reg, sent_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_unit_reg;
    logic        out_last_reg;
    logic        load;
    logic        is_last;

    assign empty     = !out_valid_reg;
    assign code_unit = out_unit_reg;
    assign run_last  = out_last_reg;

    always_comb
    begin
        load           = !qstat.empty && (!out_valid_reg || pop);
        is_last        = (sent_reg == head.count - 2'd1);
        q_rd           = load && is_last;
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            sent_next      = is_last ? 2'd0 : sent_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_unit_reg <= is_last ? head.last_unit : REPL_UNIT;
            out_last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_sent_idle: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> (sent_reg == 2'd0))
        else $error("unit index left over with no group");

    a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.empty |-> (sent_reg < head.count))
        else $error("unit index past group size");
`endif

endmodule

/* sv/utf8_to_utf16_decode.sv */
// Top level of the UTF-8 to UTF-16 stream decoder: front end, group queue, back end.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
//
//  channel   handshake           payload                      direction
//  -------   -----------------   --------------------------   ---------
//  input     push / full         data_byte[7:0], end_of_text  in
//  result    pop / empty         code_unit[15:0], run_last    out
//
// One byte is taken per cycle while full is low; the front end updates the
// sequence state in the same cycle and queues the byte's results as one group.
// The back end issues one code unit per cycle while its output is empty or popped;
// the group queue (QUEUE_DEPTH groups) absorbs bursts from bytes giving more than
// one unit, and full rises only when it has no free entry.
// An accepted byte's group is registered in the queue before its first unit is loaded into the output register.
// Reset clears the sequence state and empties the queue and the output register.
module utf8_to_utf16_decode
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] code_unit,
    output logic        run_last
);

    logic         take;
    logic         grp_valid;
    u8u16_group_t grp;
    u8u16_group_t head;
    u8u16_qstat_t qstat;
    logic         q_rd;

    // accept a byte whenever the queue has a free entry
    assign full = qstat.full;
    assign take = push && !qstat.full;

    // classify the byte and build its result group
    u8u16_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .grp_valid   (grp_valid),
        .grp         (grp)
    );

    // hold groups until the back end drains them
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (grp_valid),
        .wr_grp (grp),
        .rd     (q_rd),
        .head   (head),
        .stat   (qstat)
    );

    // advance unit by unit through the head group
    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .code_unit (code_unit),
        .run_last  (run_last)
    );

endmodule
